@@ rtl/smr_pkg.sv @@
// ----------------------------------------------------------------------------
// smr_pkg: shared types and constants of the shift-register / MCG generator
// Holds the function codes, the state layout and the table of multiplier powers.
// ----------------------------------------------------------------------------
package smr_pkg;

  localparam int unsigned SMR_WORD_W    = 32;
  localparam int unsigned SMR_OUT_W     = 31;
  localparam int unsigned SMR_IDX_W     = 7;
  localparam int unsigned SMR_TAB_DEPTH = 1 << SMR_IDX_W;

  // State memory holds {shift word, multiplier word} in a single entry.
  localparam int unsigned SMR_STATE_W     = 2 * SMR_WORD_W;
  localparam int unsigned SMR_STATE_DEPTH = 1;
  localparam int unsigned SMR_ADDR_W      = 1;

  localparam logic [SMR_WORD_W-1:0] SMR_SHIFT_MASK = 32'd593970775;
  localparam logic [SMR_WORD_W-1:0] SMR_MULT_BASE  = 32'd69069;

  typedef enum logic [0:0] {
    FUNC_RESEED = 1'b0,
    FUNC_DRAW   = 1'b1
  } func_t;

  typedef logic [SMR_TAB_DEPTH-1:0][SMR_WORD_W-1:0] pow_tab_t;

  // Entry k holds base^(128 - k) mod 2^32.
  function automatic pow_tab_t smr_build_pow_tab();
    pow_tab_t          tab;
    logic [SMR_WORD_W-1:0] p;
    p = 32'd1;
    for (int j = SMR_TAB_DEPTH - 1; j >= 0; j--) begin
      p      = p * SMR_MULT_BASE;
      tab[j] = p;
    end
    return tab;
  endfunction

  localparam pow_tab_t SMR_POW_TAB = smr_build_pow_tab();

endpackage

@@ rtl/smr_ram.sv @@
// ----------------------------------------------------------------------------
// smr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module smr_ram
  import smr_pkg::*;
#(
  parameter int unsigned WIDTH = SMR_STATE_W,
  parameter int unsigned DEPTH = SMR_STATE_DEPTH,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/shift_register_mcg_random_unit.sv @@
// ----------------------------------------------------------------------------
// shift_register_mcg_random_unit: combined shift-register / multiplicative
// congruential random generator
// Each draw beat returns one 31-bit value; a reseed beat loads the seed and
// runs one hidden step without a result.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   in_      | input     | in_valid / in_ready  | in_func (1), in_seed (32)
//   out_     | output    | out_valid / out_ready| out_random_value (31)
//
// Cycles: one beat per cycle sustained while no draw is blocked on a full
//   output register. A beat issues the state read when it is accepted, steps
//   in the step stage, writes the state back and lands in the output register.
// Throughput is set by the multiply-add loop on the state word;
//   the value written in the same cycle as a read is forwarded around the RAM.
// Reset: synchronous, active low; both state words read as zero until the
//   first write-back (a valid flag covers the RAM), no clearing pass.
// Stalls: a draw waiting for a full output register holds the step stage and
//   drops in_ready; a reseed never waits on the output side.
// ----------------------------------------------------------------------------
module shift_register_mcg_random_unit
  import smr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [0:0]            in_func,
  input  logic [SMR_WORD_W-1:0] in_seed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SMR_OUT_W-1:0]  out_random_value
);

  // Handshakes
  logic in_fire;
  logic s1_go;

  // Step stage: item held while its state read is in flight
  logic                  s1_valid_r, s1_valid_nxt;
  func_t                 s1_func_r;
  logic [SMR_WORD_W-1:0] s1_seed_r;
  logic                  s1_fwd_r;      // state written at the edge of the read

  // State memory and forwarding
  logic [SMR_ADDR_W-1:0]  state_addr;
  logic [SMR_STATE_W-1:0] ram_rdata;
  logic [SMR_STATE_W-1:0] wr_data;
  logic [SMR_STATE_W-1:0] fwd_data_r;
  logic                   written_r;     // RAM entry holds a real value

  // Step datapath
  logic [SMR_STATE_W-1:0] cur_state;
  logic [SMR_WORD_W-1:0]  cur_shift;
  logic [SMR_WORD_W-1:0]  cur_mult;
  logic [SMR_WORD_W-1:0]  new_shift;
  logic [SMR_WORD_W-1:0]  nit;
  logic [SMR_WORD_W-1:0]  pow_val;
  logic [SMR_WORD_W-1:0]  prod;
  logic [SMR_WORD_W-1:0]  new_mult;
  logic [SMR_OUT_W-1:0]   step_result;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [SMR_OUT_W-1:0] out_value_r;

  assign state_addr = '0;

  // Advance the step stage when it holds a reseed, or a draw that can land
  // in the output register this cycle.
  assign s1_go    = s1_valid_r && ((s1_func_r == FUNC_RESEED) || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
      written_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        // The read issued now misses a write landing at the same edge.
        s1_fwd_r <= s1_go;
      end
      if (s1_go) begin
        written_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= func_t'(in_func);
      s1_seed_r <= in_seed;
    end
    if (s1_go) begin
      fwd_data_r <= wr_data;
    end
  end

  smr_ram #(
    .WIDTH (SMR_STATE_W),
    .DEPTH (SMR_STATE_DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (state_addr),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (state_addr),
    .rdata (ram_rdata)
  );

  // Pick the current state: forwarded write-back first, then RAM, else reset.
  always_comb begin
    priority if (s1_fwd_r) begin
      cur_state = fwd_data_r;
    end else if (written_r) begin
      cur_state = ram_rdata;
    end else begin
      cur_state = '0;
    end
  end

  // One generator step. A reseed replaces the state by {seed, 0} first.
  always_comb begin
    unique case (s1_func_r)
      FUNC_RESEED: begin
        cur_shift = s1_seed_r;
        cur_mult  = '0;
      end
      FUNC_DRAW: begin
        cur_shift = cur_state[SMR_STATE_W-1:SMR_WORD_W];
        cur_mult  = cur_state[SMR_WORD_W-1:0];
      end
      default: begin
        cur_shift = cur_state[SMR_STATE_W-1:SMR_WORD_W];
        cur_mult  = cur_state[SMR_WORD_W-1:0];
      end
    endcase

    // Double the shift word; fold in the mask when it was zero or negative.
    new_shift = {cur_shift[SMR_WORD_W-2:0], 1'b0};
    if (cur_shift[SMR_WORD_W-1] || (cur_shift == '0)) begin
      new_shift = new_shift ^ SMR_SHIFT_MASK;
    end

    nit      = new_shift - SMR_WORD_W'(1);
    pow_val  = SMR_POW_TAB[nit[SMR_IDX_W-1:0]];
    prod     = cur_mult * pow_val;
    new_mult = prod + nit;

    // Fold the sign: invert a negative multiplier word.
    step_result = new_mult[SMR_WORD_W-1] ? ~new_mult[SMR_OUT_W-1:0]
                                         : new_mult[SMR_OUT_W-1:0];
  end

  assign wr_data = {new_shift, new_mult};

  // Output register: load on a draw that leaves the step stage, drop on take.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && (s1_func_r == FUNC_DRAW)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_func_r == FUNC_DRAW)) begin
      out_value_r <= step_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Input backpressure only comes from a draw blocked on a full output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && (s1_func_r == FUNC_DRAW) && out_valid_r && !out_ready))
    else $error("in_ready low without a blocked draw");

  // A read issued together with a write-back must take the forwarded value.
  a_fwd_set: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s1_go) |=> s1_fwd_r)
    else $error("forwarding flag missed a same-edge write-back");

  // A reseed leaving the step stage never creates a result.
  a_reseed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && (s1_func_r == FUNC_RESEED) && !out_valid_r) |=> !out_valid_r)
    else $error("reseed produced a result");

  // Once the state RAM holds a value it stays valid.
  a_written_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    written_r |=> written_r)
    else $error("state valid flag dropped");

endmodule

@@ verif/smr_random_checker.sv @@
// ----------------------------------------------------------------------------
// smr_random_checker: result checker for the shift-register / MCG generator
// Watches both channels, predicts each draw from its own copy of the state
// and compares every out beat with the oldest prediction.
// ----------------------------------------------------------------------------
module smr_random_checker
  import smr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [0:0]            in_func,
  input  logic [SMR_WORD_W-1:0] in_seed,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SMR_OUT_W-1:0]  out_random_value,
  input  logic                  end_of_run,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [SMR_WORD_W-1:0] pred_shift;
  logic [SMR_WORD_W-1:0] pred_mult;
  logic [SMR_OUT_W-1:0]  expected_values[$];
  logic [SMR_OUT_W-1:0]  want;
  logic [SMR_OUT_W-1:0]  discard;
  bit                    leftovers_reported;

  initial begin
    mismatches         = 0;
    outstanding        = 0;
    results_checked    = 0;
    leftovers_reported = 1'b0;
    pred_shift         = '0;
    pred_mult          = '0;
  end

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // base^e mod 2^32 by square and multiply
  function automatic logic [SMR_WORD_W-1:0] base_power(input int unsigned e);
    logic [SMR_WORD_W-1:0] acc;
    logic [SMR_WORD_W-1:0] sq;
    acc = 32'd1;
    sq  = SMR_MULT_BASE;
    while (e != 0) begin
      if ((e & 1) != 0) acc = acc * sq;
      sq = sq * sq;
      e  = e >> 1;
    end
    return acc;
  endfunction

  // Advance the predicted state by one step and return the folded value.
  function automatic logic [SMR_OUT_W-1:0] gen_step();
    logic [SMR_WORD_W-1:0] sw;
    logic [SMR_WORD_W-1:0] lead;
    sw = pred_shift;
    if (sw == '0 || sw[SMR_WORD_W-1]) sw = (sw << 1) ^ SMR_SHIFT_MASK;
    else sw = sw << 1;
    lead       = sw - 32'd1;
    pred_mult  = pred_mult * base_power(128 - lead[SMR_IDX_W-1:0]) + lead;
    pred_shift = sw;
    return pred_mult[SMR_WORD_W-1] ? ~pred_mult[SMR_OUT_W-1:0] : pred_mult[SMR_OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pred_shift = '0;
      pred_mult  = '0;
      expected_values.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (func_t'(in_func) == FUNC_RESEED) begin
          pred_shift = in_seed;
          pred_mult  = '0;
          discard    = gen_step();
        end else begin
          expected_values.push_back(gen_step());
        end
      end
      if (out_valid && out_ready) begin
        if (expected_values.size() == 0) begin
          note_mismatch($sformatf("unexpected result %h", out_random_value));
        end else begin
          want = expected_values.pop_front();
          results_checked++;
          if (out_random_value !== want)
            note_mismatch($sformatf("random_value %h, expected %h", out_random_value, want));
        end
      end
      if (end_of_run && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        if (expected_values.size() != 0)
          note_mismatch($sformatf("%0d results never arrived", expected_values.size()));
      end
      outstanding = expected_values.size();
    end
  end

endmodule

@@ verif/tb_shift_register_mcg_random_unit.sv @@
// ----------------------------------------------------------------------------
// tb_shift_register_mcg_random_unit: testbench top of the random generator
// Drives reseed and draw beats under several idle/stall mixes, holds the
// output off once to back the unit up, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_shift_register_mcg_random_unit
  import smr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 450;
  localparam int HOLD_OFF_CYCLES  = 200;
  localparam int IDLE_LIMIT       = 4000;  // cycles without any beat
  localparam int DRAIN_LIMIT      = 2000;
  localparam int TAIL_CYCLES      = 8;     // margin for a late stray result

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [0:0]            in_func;
  logic [SMR_WORD_W-1:0] in_seed;
  logic                  out_valid;
  logic                  out_ready;
  logic [SMR_OUT_W-1:0]  out_random_value;
  logic                  end_of_run;

  int mismatches;
  int outstanding;
  int results_checked;

  // Idle/stall percentages of the current phase.
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  // Hold-off handshake between the stimulus and the receiver process.
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  int draws_sent   = 0;
  int reseeds_sent = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  shift_register_mcg_random_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_seed          (in_seed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

  smr_random_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_seed          (in_seed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .end_of_run       (end_of_run),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked)
  );

  // Offer one beat from a falling edge and return at the falling edge after
  // it is taken. Valid stays high on return so back-to-back beats never
  // drop it; an idle gap lowers it before the next payload goes out.
  task automatic offer_beat(input func_t f, input logic [SMR_WORD_W-1:0] s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      in_func  = 1'($urandom);
      in_seed  = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_func  = f;
    in_seed  = s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (f == FUNC_DRAW) draws_sent++;
    else reseeds_sent++;
  endtask

  // Mostly full-range seeds, with a share of the corner values.
  function automatic logic [SMR_WORD_W-1:0] pick_seed();
    unique case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: stall at the phase's rate, or hold off completely on request.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAIL shift_register_mcg_random_unit");
        $finish;
      end
    end
  end

  initial begin
    int waited;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_func    = FUNC_DRAW;
    in_seed    = '0;
    end_of_run = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: draws straight out of reset (both words zero), then the
    // seed corners, a zero seed, back-to-back reseeds and a lone draw.
    repeat (3) offer_beat(FUNC_DRAW, $urandom);
    offer_beat(FUNC_RESEED, '0);
    repeat (2) offer_beat(FUNC_DRAW, '1);
    offer_beat(FUNC_RESEED, '1);
    repeat (2) offer_beat(FUNC_DRAW, '0);
    offer_beat(FUNC_RESEED, 32'h8000_0000);
    offer_beat(FUNC_DRAW, '0);
    offer_beat(FUNC_RESEED, 32'h7FFF_FFFF);
    offer_beat(FUNC_DRAW, '0);
    offer_beat(FUNC_RESEED, 32'h0000_0001);
    offer_beat(FUNC_RESEED, 32'hAAAA_AAAA);
    offer_beat(FUNC_DRAW, 32'h5555_5555);
    offer_beat(FUNC_RESEED, 32'h5555_5555);
    repeat (3) offer_beat(FUNC_DRAW, 32'hAAAA_AAAA);

    // Random phases: no idling, idle sender, stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin src_idle_pct = 22; sink_stall_pct = 22; end
      endcase
      // Back the unit up once while the sender keeps offering.
      if (phase == 0) hold_requests++;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(99) < 15) offer_beat(FUNC_RESEED, pick_seed());
        else offer_beat(FUNC_DRAW, $urandom);
      end
    end
    in_valid = 1'b0;

    // Drain, then give any stray beat time to show up.
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    end_of_run = 1'b1;
    @(posedge clk);
    @(negedge clk);

    $display("covered %0d draw and %0d reseed beats over four idle/stall mixes",
             draws_sent, reseeds_sent);
    $display("checked %0d results, including a %0d-cycle output hold-off",
             results_checked, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("PASS shift_register_mcg_random_unit");
    end else begin
      $display("FAIL shift_register_mcg_random_unit");
    end
    $finish;
  end

endmodule
